FILE: hw/rtl/text_grid_layout_unit_macros.svh
// ---------------------------------------------------------------------------
// text grid layout assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset masked
// ---------------------------------------------------------------------------
`ifndef TEXT_GRID_LAYOUT_UNIT_MACROS_SVH
`define TEXT_GRID_LAYOUT_UNIT_MACROS_SVH

// implication checked in the next cycle
`define TGL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("text grid layout: next-cycle check failed");

// implication checked in the same cycle
`define TGL_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("text grid layout: same-cycle check failed");

`endif

FILE: hw/rtl/tgl_pkg.sv
// ---------------------------------------------------------------------------
// tgl_pkg
// shared types, register indexes and limits of the text grid layout unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgl_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;

    localparam logic [8:0]  COLS_LIMIT   = 9'(MAX_COLS);
    localparam logic [7:0]  ROWS_LIMIT   = 8'(MAX_ROWS);

    localparam logic [24:0] SKIP_MAX     = 25'h1FFFFFF;
    localparam logic [15:0] LINE_CNT_MAX = 16'hFFFF;
    localparam logic [16:0] LINE_POS_MAX = 17'h1FFFF;
    localparam logic [7:0]  OUT_ROW_MAX  = 8'hFF;
    localparam logic [8:0]  OUT_COL_MAX  = 9'h1FF;

    localparam logic [7:0]  CHAR_LF      = 8'h0A;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_DEL     = 8'd127;

    typedef enum logic [2:0] {
        REG_LINE_MODE    = 3'd0,
        REG_ROW_OFFSET   = 3'd1,
        REG_COL_OFFSET   = 3'd2,
        REG_SKIP_STRIDE  = 3'd3,
        REG_COLS_VISIBLE = 3'd4,
        REG_ROWS_VISIBLE = 3'd5
    } tgl_reg_e;

    typedef enum logic [1:0] {
        MODE_WRAP = 2'd0,
        MODE_CRLF = 2'd1,
        MODE_LF   = 2'd2,
        MODE_OFF  = 2'd3
    } tgl_mode_e;

    typedef struct packed {
        tgl_mode_e   line_mode;
        logic [15:0] row_offset;
        logic [15:0] col_offset;
        logic [8:0]  cols;
        logic [7:0]  rows;
        logic [24:0] skip_base;
        logic        busy;
    } tgl_cfg_t;

    typedef struct packed {
        logic [24:0] skipped_count;
        logic [15:0] line_count;
        logic [16:0] line_pos;
        logic        cr_flag;
        logic [7:0]  out_row;
        logic [8:0]  out_col;
    } tgl_state_t;

    typedef struct packed {
        logic       shown;
        logic [6:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] glyph;
        logic       printable;
        logic       done_res;
    } tgl_res_t;

endpackage

FILE: hw/rtl/tgl_cfg.sv
// ---------------------------------------------------------------------------
// tgl_cfg
// configuration registers, clamped grid size and registered wrap skip count
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgl_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output tgl_pkg::tgl_cfg_t cfg
);
    import tgl_pkg::*;

    tgl_mode_e   line_mode_reg;
    logic [15:0] row_offset_reg;
    logic [15:0] col_offset_reg;
    logic [8:0]  skip_stride_reg;
    logic [8:0]  cols_visible_reg;
    logic [7:0]  rows_visible_reg;
    logic [24:0] skip_base_reg;
    logic [24:0] skip_base_next;
    logic        busy_reg;
    logic        busy_next;
    logic        wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    assign skip_base_next = 25'(row_offset_reg) * 25'(skip_stride_reg) + 25'(col_offset_reg);
    // skip base is registered from the offset and stride registers that a write updates
    assign busy_next      = wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg    <= MODE_WRAP;
            row_offset_reg   <= '0;
            col_offset_reg   <= '0;
            skip_stride_reg  <= 9'd80;
            cols_visible_reg <= 9'd80;
            rows_visible_reg <= 8'd25;
            skip_base_reg    <= '0;
            busy_reg         <= 1'b0;
        end
        else
        begin
            skip_base_reg <= skip_base_next;
            busy_reg      <= busy_next;
            if (wr_en)
            begin
                unique case (cfg_index)
                    REG_LINE_MODE:    line_mode_reg    <= tgl_mode_e'(cfg_data[1:0]);
                    REG_ROW_OFFSET:   row_offset_reg   <= cfg_data;
                    REG_COL_OFFSET:   col_offset_reg   <= cfg_data;
                    REG_SKIP_STRIDE:  skip_stride_reg  <= cfg_data[8:0];
                    REG_COLS_VISIBLE: cols_visible_reg <= cfg_data[8:0];
                    REG_ROWS_VISIBLE: rows_visible_reg <= cfg_data[7:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.line_mode  = line_mode_reg;
        cfg.row_offset = row_offset_reg;
        cfg.col_offset = col_offset_reg;
        cfg.cols       = (cols_visible_reg > COLS_LIMIT) ? COLS_LIMIT : cols_visible_reg;
        cfg.rows       = (rows_visible_reg > ROWS_LIMIT) ? ROWS_LIMIT : rows_visible_reg;
        cfg.skip_base  = skip_base_reg;
        cfg.busy       = busy_reg;
    end

endmodule

FILE: hw/rtl/tgl_core.sv
// ---------------------------------------------------------------------------
// tgl_core
// layout state and the per-byte placement logic for the wrap, CR/LF and LF modes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_grid_layout_unit_macros.svh"

module tgl_core (
    input  logic              clk,
    input  logic              rst_n,
    input  tgl_pkg::tgl_cfg_t cfg,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output tgl_pkg::tgl_res_t res
);
    import tgl_pkg::*;

    tgl_state_t  state_reg;
    tgl_state_t  state_next;
    tgl_state_t  step;
    logic [8:0]  col_inc;
    logic [16:0] pos_diff;
    logic        ends;

    always_comb
    begin
        step         = state_reg;
        res          = '0;
        res.glyph    = data_byte;
        res.printable = (data_byte < CHAR_DEL);
        res.done_res = last_byte;
        col_inc      = (state_reg.out_col != OUT_COL_MAX) ? state_reg.out_col + 9'd1
                                                          : state_reg.out_col;
        pos_diff     = state_reg.line_pos - {1'b0, cfg.col_offset};
        ends         = 1'b0;

        unique case (cfg.line_mode)
            MODE_WRAP:
            begin
                if (state_reg.skipped_count < cfg.skip_base)
                begin
                    if (state_reg.skipped_count != SKIP_MAX)
                        step.skipped_count = state_reg.skipped_count + 25'd1;
                end
                else
                begin
                    if (state_reg.out_row < cfg.rows && state_reg.out_col < cfg.cols)
                    begin
                        res.shown    = 1'b1;
                        res.cell_row = state_reg.out_row[6:0];
                        res.cell_col = state_reg.out_col[7:0];
                    end
                    if (col_inc >= cfg.cols)
                    begin
                        step.out_col = '0;
                        if (state_reg.out_row != OUT_ROW_MAX)
                            step.out_row = state_reg.out_row + 8'd1;
                    end
                    else
                    begin
                        step.out_col = col_inc;
                    end
                end
            end
            MODE_CRLF, MODE_LF:
            begin
                if (cfg.line_mode == MODE_LF)
                    ends = (data_byte == CHAR_LF);
                else
                    ends = state_reg.cr_flag && (data_byte == CHAR_LF);
                step.cr_flag = (data_byte == CHAR_CR);

                if (state_reg.line_count >= cfg.row_offset && state_reg.out_row < cfg.rows &&
                    state_reg.line_pos >= {1'b0, cfg.col_offset} &&
                    pos_diff < {8'd0, cfg.cols})
                begin
                    res.shown    = 1'b1;
                    res.cell_row = state_reg.out_row[6:0];
                    res.cell_col = pos_diff[7:0];
                end

                if (ends)
                begin
                    step.line_pos = '0;
                    if (state_reg.line_count < cfg.row_offset)
                    begin
                        if (state_reg.line_count != LINE_CNT_MAX)
                            step.line_count = state_reg.line_count + 16'd1;
                    end
                    else if (state_reg.out_row != OUT_ROW_MAX)
                    begin
                        step.out_row = state_reg.out_row + 8'd1;
                    end
                end
                else if (state_reg.line_pos != LINE_POS_MAX)
                begin
                    step.line_pos = state_reg.line_pos + 17'd1;
                end
            end
            default:
            begin
            end
        endcase

        // end of buffer returns the layout to its start
        state_next = last_byte ? tgl_state_t'('0) : step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    `TGL_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && last_byte, state_reg == '0)
    `TGL_ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !advance, $stable(state_reg))
    `TGL_ASSERT_NEXT(a_off_mode_frozen, clk, rst_n, advance && !last_byte && cfg.line_mode == MODE_OFF, $stable(state_reg))
    `TGL_ASSERT_NOW(a_shown_in_grid, clk, rst_n, res.shown, {1'b0, res.cell_col} < cfg.cols)

endmodule

FILE: hw/rtl/text_grid_layout_unit.sv
// a request is registered on acceptance, its result when the core advances
// throughput: one request per cycle without stalls, limited by the single core state update
// a configuration write holds back processing while the skip base settles
// reset: asynchronous active low, registers return to defaults and layout state clears
// ---------------------------------------------------------------------------
// text_grid_layout_unit
// places a byte stream on a character grid, in wrap, CR/LF or LF line mode
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_grid_layout_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        shown,
    output logic [6:0]  cell_row,
    output logic [7:0]  cell_col,
    output logic [7:0]  glyph,
    output logic        printable,
    output logic        done_res
);
    import tgl_pkg::*;

    tgl_cfg_t   cfg;
    tgl_res_t   res;
    tgl_res_t   res_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       advance;

    tgl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    assign out_free       = !out_valid_reg || out_ready;
    assign advance        = in_valid_reg && out_free && !cfg.busy;
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = out_free ? advance : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance)
            res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign shown     = res_reg.shown;
    assign cell_row  = res_reg.cell_row;
    assign cell_col  = res_reg.cell_col;
    assign glyph     = res_reg.glyph;
    assign printable = res_reg.printable;
    assign done_res  = res_reg.done_res;

endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for text_grid_layout_unit: directed grid layouts,
// counter saturation, an output hold-off and random byte streams in every
// line mode, each cell result checked field by field against a layout
// predictor kept inside the bench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import tgl_pkg::*;

    localparam int         CLK_PERIOD      = 10;
    localparam int         LATENCY_SLACK   = 8;
    localparam int         RANDOM_BYTES    = 1200;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         MAX_REPORTS     = 40;
    localparam longint     TIMEOUT_NS      = 2_000_000;
    localparam logic [2:0] REG_SPARE_A     = 3'd6;
    localparam logic [2:0] REG_SPARE_B     = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        shown;
    logic [6:0]  cell_row;
    logic [7:0]  cell_col;
    logic [7:0]  glyph;
    logic        printable;
    logic        done_res;

    // predictor copy of the registers
    tgl_mode_e   mode_r;
    logic [15:0] row_off_r;
    logic [15:0] col_off_r;
    logic [8:0]  stride_r;
    logic [8:0]  cols_r;
    logic [7:0]  rows_r;

    // predictor copy of the layout state
    logic [24:0] skipped;
    logic [15:0] lines_skipped;
    logic [16:0] pos_in_line;
    logic        after_cr;
    logic [7:0]  grid_row;
    logic [8:0]  grid_col;

    tgl_res_t    cells_due [$];

    int errors          = 0;
    int bytes_sent      = 0;
    int cells_checked   = 0;
    int cells_shown     = 0;
    int stall_cycles    = 0;
    int hold_off_cycles = 0;
    bit in_gaps_on      = 1'b1;
    bit out_gaps_on     = 1'b1;

    text_grid_layout_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .shown     (shown),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .glyph     (glyph),
        .printable (printable),
        .done_res  (done_res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("cell %0d %s: got %0h, want %0h",
                                      cells_checked, name, got, want));
    endtask

    task automatic clear_layout_state();
        skipped       = '0;
        lines_skipped = '0;
        pos_in_line   = '0;
        after_cr      = 1'b0;
        grid_row      = '0;
        grid_col      = '0;
    endtask

    // works out the cell for one accepted byte and queues it
    task automatic lay_out_byte(input logic [7:0] b, input logic lst);
        logic [8:0]  cols;
        logic [7:0]  rows;
        logic [31:0] skip_base;
        logic        ends;
        tgl_res_t    item_res;
        cols = (cols_r < COLS_LIMIT) ? cols_r : COLS_LIMIT;
        rows = (rows_r < ROWS_LIMIT) ? rows_r : ROWS_LIMIT;
        item_res = '0;
        case (mode_r)
            MODE_WRAP:
            begin
                skip_base = 32'(col_off_r) + 32'(row_off_r) * 32'(stride_r);
                if (32'(skipped) < skip_base)
                begin
                    if (skipped != SKIP_MAX)
                        skipped++;
                end
                else
                begin
                    if (grid_row < rows && grid_col < cols)
                    begin
                        item_res.shown    = 1'b1;
                        item_res.cell_row = grid_row[6:0];
                        item_res.cell_col = grid_col[7:0];
                    end
                    if (grid_col != OUT_COL_MAX)
                        grid_col++;
                    if (grid_col >= cols)
                    begin
                        grid_col = '0;
                        if (grid_row != OUT_ROW_MAX)
                            grid_row++;
                    end
                end
            end
            MODE_CRLF, MODE_LF:
            begin
                ends     = (b == CHAR_LF) && (mode_r == MODE_LF || after_cr);
                after_cr = (b == CHAR_CR);
                if (lines_skipped >= row_off_r && grid_row < rows &&
                    pos_in_line >= 17'(col_off_r) &&
                    (pos_in_line - 17'(col_off_r)) < 17'(cols))
                begin
                    item_res.shown    = 1'b1;
                    item_res.cell_row = grid_row[6:0];
                    item_res.cell_col = 8'(pos_in_line - 17'(col_off_r));
                end
                if (ends)
                begin
                    pos_in_line = '0;
                    if (lines_skipped < row_off_r)
                    begin
                        if (lines_skipped != LINE_CNT_MAX)
                            lines_skipped++;
                    end
                    else if (grid_row != OUT_ROW_MAX)
                        grid_row++;
                end
                else if (pos_in_line != LINE_POS_MAX)
                    pos_in_line++;
            end
            default: ;
        endcase
        item_res.glyph     = b;
        item_res.printable = (b < CHAR_DEL);
        item_res.done_res  = lst;
        if (item_res.shown)
            cells_shown++;
        if (lst)
            clear_layout_state();
        cells_due.push_back(item_res);
    endtask

    function automatic logic [15:0] with_junk(input int unsigned val, input int width);
        logic [31:0] junk;
        junk = $urandom;
        return 16'(val | (junk << width));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LINE_MODE:    mode_r    = tgl_mode_e'(val[1:0]);
            REG_ROW_OFFSET:   row_off_r = val;
            REG_COL_OFFSET:   col_off_r = val;
            REG_SKIP_STRIDE:  stride_r  = val[8:0];
            REG_COLS_VISIBLE: cols_r    = val[8:0];
            REG_ROWS_VISIBLE: rows_r    = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_grid(input tgl_mode_e m, input int unsigned row_off,
                              input int unsigned col_off, input int unsigned stride,
                              input int unsigned cols, input int unsigned rows);
        write_reg(REG_LINE_MODE, with_junk(m, 2));
        write_reg(REG_ROW_OFFSET, 16'(row_off));
        write_reg(REG_COL_OFFSET, 16'(col_off));
        write_reg(REG_SKIP_STRIDE, with_junk(stride, 9));
        write_reg(REG_COLS_VISIBLE, with_junk(cols, 9));
        write_reg(REG_ROWS_VISIBLE, with_junk(rows, 8));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while (in_gaps_on && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        lay_out_byte(b, lst);
    endtask

    task automatic send_text(input string s, input bit closes);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], closes && i == s.len() - 1);
    endtask

    // wait until every outstanding request has its cell back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_cells
        tgl_res_t want;
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                stall_cycles++;
            if (out_valid && out_ready)
            begin
                cells_checked++;
                if (cells_due.size() == 0)
                    report_mismatch($sformatf("cell %0d arrived with nothing outstanding",
                                              cells_checked));
                else
                begin
                    want = cells_due.pop_front();
                    compare_field("shown", shown, want.shown);
                    compare_field("cell_row", cell_row, want.cell_row);
                    compare_field("cell_col", cell_col, want.cell_col);
                    compare_field("glyph", glyph, want.glyph);
                    compare_field("printable", printable, want.printable);
                    compare_field("done_res", done_res, want.done_res);
                end
            end
        end
    end

    initial
    begin : drive_out_ready
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready <= !out_gaps_on || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic test_reset_defaults();
        logic [7:0] probe [8] = '{8'h00, 8'hFF, 8'h7E, 8'h7F, 8'h80, 8'h55, 8'hAA, 8'h01};
        foreach (probe[i])
            send_byte(probe[i], i == 7);
    endtask

    task automatic test_wrap_skip();
        settle();
        write_grid(MODE_WRAP, 1, 2, 3, 4, 2);
        send_text("0123456789ABCDEF", 1'b1);
    endtask

    task automatic test_zero_sizes();
        settle();
        write_grid(MODE_WRAP, 5, 1, 0, 3, 2);
        send_text("abcdefgh", 1'b1);
        settle();
        write_reg(REG_COLS_VISIBLE, 16'd0);
        send_text("xyz", 1'b1);
        settle();
        write_reg(REG_COLS_VISIBLE, 16'd3);
        write_reg(REG_ROWS_VISIBLE, 16'd0);
        send_text("xyz", 1'b1);
    endtask

    task automatic test_line_modes();
        settle();
        write_grid(MODE_CRLF, 1, 1, 80, 3, 3);
        send_text("skip\r\nabcde\r\nx\ry\nz\r\n", 1'b0);
        send_text("tail\r", 1'b1);
        send_text("ab\r\ncd", 1'b1);
        settle();
        write_reg(REG_LINE_MODE, MODE_LF);
        send_text("a\nbcd\n\nefghij\n", 1'b1);
    endtask

    // an open wrap stream survives a spell in the off mode
    task automatic test_mode_off();
        settle();
        write_grid(MODE_WRAP, 0, 0, 80, 4, 2);
        send_text("abc", 1'b0);
        settle();
        write_reg(REG_LINE_MODE, MODE_OFF);
        send_text("d\ne", 1'b0);
        settle();
        write_reg(REG_LINE_MODE, MODE_WRAP);
        send_text("fgh", 1'b1);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        write_grid(MODE_WRAP, 16'hFFFF, 16'hFFFF, 511, 511, 255);
        send_text("hello", 1'b1);
        settle();
        write_reg(REG_LINE_MODE, MODE_LF);
        send_text("ab\ncd", 1'b1);
        settle();
        write_reg(REG_LINE_MODE, MODE_CRLF);
        send_text("ab\r\ncd", 1'b1);
        settle();
        write_grid(MODE_WRAP, 0, 0, 0, 256, 128);
        send_text("WXYZ", 1'b1);
    endtask

    task automatic test_saturation();
        settle();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        write_grid(MODE_WRAP, 0, 0, 1, 1, 255);
        for (int i = 0; i < 300; i++)
            send_byte(8'($urandom), i == 299);
        settle();
        write_grid(MODE_LF, 0, 0, 1, 256, 255);
        for (int i = 0; i < 300; i++)
            send_byte(CHAR_LF, i == 299);
        settle();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        settle();
        write_grid(MODE_WRAP, 0, 3, 2, 8, 4);
        in_gaps_on      = 1'b0;
        hold_off_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 120; i++)
            send_byte(8'($urandom), i == 119);
        in_gaps_on = 1'b1;
    endtask

    task automatic pick_layout();
        int r;
        tgl_mode_e m;
        r = $urandom_range(0, 99);
        m = (r < 30) ? MODE_WRAP : (r < 60) ? MODE_CRLF : (r < 92) ? MODE_LF : MODE_OFF;
        write_reg(REG_LINE_MODE, with_junk(m, 2));
        if ($urandom_range(0, 3) != 0)
        begin
            r = $urandom_range(0, 99);
            write_reg(REG_ROW_OFFSET, (r < 80) ? 16'($urandom_range(0, 3)) :
                                      (r < 95) ? 16'($urandom_range(4, 40)) : 16'($urandom));
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_COL_OFFSET, ($urandom_range(0, 99) < 80) ?
                                      16'($urandom_range(0, 6)) : 16'($urandom));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_SKIP_STRIDE, with_junk(($urandom_range(0, 99) < 70) ?
                                       $urandom_range(0, 8) : $urandom_range(0, 511), 9));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_COLS_VISIBLE, with_junk(($urandom_range(0, 99) < 85) ?
                                        $urandom_range(0, 24) : $urandom_range(0, 511), 9));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_ROWS_VISIBLE, with_junk(($urandom_range(0, 99) < 85) ?
                                        $urandom_range(0, 10) : $urandom_range(0, 255), 8));
        if ($urandom_range(0, 19) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    endtask

    // text-like lines for the line modes, with stray terminators and raw bytes
    task automatic send_random_stream(input int n, input bit closes);
        int k;
        int r;
        logic [7:0] b;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 99);
            if (mode_r != MODE_WRAP && r < 14)
            begin
                if (mode_r == MODE_CRLF)
                begin
                    send_byte(CHAR_CR, 1'b0);
                    k++;
                end
                b = CHAR_LF;
            end
            else if (r < 20)
                b = r[0] ? CHAR_CR : CHAR_LF;
            else if (r < 70)
                b = 8'($urandom_range(8'h20, 8'h7E));
            else
                b = 8'($urandom);
            k++;
            send_byte(b, (closes && k >= n) || $urandom_range(0, 99) == 0);
        end
    endtask

    task automatic test_random_streams();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            settle();
            pick_layout();
            in_gaps_on  = !(sent >= 800 && sent < 1100);
            out_gaps_on = in_gaps_on;
            len = $urandom_range(10, 90);
            send_random_stream(len, $urandom_range(0, 99) < 80);
            sent += len;
        end
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LINE_MODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        mode_r    = MODE_WRAP;
        row_off_r = '0;
        col_off_r = '0;
        stride_r  = 9'd80;
        cols_r    = 9'd80;
        rows_r    = 8'd25;
        clear_layout_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_wrap_skip();
        test_zero_sizes();
        test_line_modes();
        test_mode_off();
        test_register_extremes();
        test_saturation();
        test_backpressure();
        test_random_streams();
        settle();

        $display("covered directed grids, saturating counters, a %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        $display("%0d bytes laid out, %0d cells checked, %0d shown, %0d input stall cycles",
                 bytes_sent, cells_checked, cells_shown, stall_cycles);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
